[rtl/core/ray_sphere_shade_assert.svh]
// ray_sphere_shade_assert.svh: assertion macros for the ray/sphere shader.
// Expects aclk and aresetn in the scope of each use; no other dependencies.
`ifndef RAY_SPHERE_SHADE_ASSERT_SVH
`define RAY_SPHERE_SHADE_ASSERT_SVH
`ifndef SYNTHESIS
`define RSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rss: same-cycle check failed");
`define RSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rss: next-cycle check failed");
`else
`define RSS_ASSERT_NOW(lbl, ante, cons)
`define RSS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/rss_pkg.sv]
// rss_pkg: shared constants and codes of the ray/sphere shader.
// No dependencies; used by ray_sphere_shade.
package rss_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 12;

    // register map
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Z = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS   = 3'd6;

    // normal components are cut down below 2^NORM_BITS before the length
    localparam int NORM_BITS = 30;

    // byte = floor(SCALE_NUM * num / den)
    localparam int SCALE_NUM = 255999;
    localparam int HIT_DEN   = 2000;
    localparam int SKY_R_DEN = 4000;
    localparam int SKY_G_DEN = 20000;
    localparam int SKY_R_L   = 3;
    localparam int SKY_G_L   = 17;
    localparam int SKY_G_Y   = 3;

    localparam logic [7:0] BYTE_ZERO = 8'd0;
    localparam logic [7:0] BYTE_MID  = 8'd127;
    localparam logic [7:0] BYTE_FULL = 8'd255;

    // fixed channel outcomes that bypass the divider result
    typedef enum logic [1:0] {
        OVR_NONE,
        OVR_ZERO,
        OVR_MID,
        OVR_FULL
    } ovr_t;

endpackage

[rtl/core/rss_isqrt.sv]
// rss_isqrt: pipelined integer square root, one root bit per stage.
// Carries a side payload alongside; stalls on en low. No package use.
module rss_isqrt #(
    parameter int IW = 66,
    parameter int PW = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [IW-1:0]           in_value,
    input  logic [PW-1:0]           in_pl,
    output logic                    out_valid,
    output logic [(IW+1)/2-1:0]     out_root,
    output logic [PW-1:0]           out_pl
);
    localparam int OW = (IW + 1) / 2;
    localparam int TW = IW + 2;

    logic [IW-1:0] rem_reg  [OW];
    logic [OW-1:0] root_reg [OW];
    logic [PW-1:0] pl_reg   [OW];
    logic          vld_reg  [OW];

    for (genvar j = 0; j < OW; j++) begin : g_step
        localparam int B = OW - 1 - j;
        logic [IW-1:0] rem_src;
        logic [OW-1:0] root_src;
        logic [PW-1:0] pl_src;
        logic          v_src;
        logic [TW-1:0] trial;
        logic          take;
        logic [IW-1:0] rem_next;
        logic [OW-1:0] root_next;

        if (j == 0) begin : g_first
            assign rem_src  = in_value;
            assign root_src = '0;
            assign pl_src   = in_pl;
            assign v_src    = in_valid;
        end else begin : g_chain
            assign rem_src  = rem_reg[j-1];
            assign root_src = root_reg[j-1];
            assign pl_src   = pl_reg[j-1];
            assign v_src    = vld_reg[j-1];
        end

        // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
        assign trial     = (TW'(root_src) << (B + 1)) | (TW'(1) << (2 * B));
        assign take      = TW'(rem_src) >= trial;
        assign rem_next  = take ? IW'(TW'(rem_src) - trial) : rem_src;
        assign root_next = take ? (root_src | (OW'(1) << B)) : root_src;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                pl_reg[j]   <= pl_src;
            end
        end
    end

    assign out_valid = vld_reg[OW-1];
    assign out_root  = root_reg[OW-1];
    assign out_pl    = pl_reg[OW-1];

endmodule

[rtl/core/ray_sphere_shade.sv]
// ray_sphere_shade: shades one ray against one sphere per word, fully pipelined.
// Uses rss_pkg (constants, codes) and rss_isqrt (pipelined square root).
//
// Usage
//   Input channel s_*: one ray direction (dir_x/y/z, signed fixed point) a word.
//   Output channel m_*: one colour word per input word, in order: red, green,
//   blue bytes, plus hit (sphere struck in front of the origin) and
//   degenerate (zero direction, colour black).
//   Config port cfg_*: origin, centre and radius, written by index while the
//   pipe is empty; writes take effect at once, unknown indexes are dropped.
// Timing
//   A new word may enter every cycle unless the receiver stalls. The pipe
//   holds the two bit-serial square-root pipelines (2*COORD_WIDTH+1 and
//   31 stages) and the 8-step byte divider.
// Flow control
//   The whole pipe advances together whenever the output register is empty
//   or being taken; while the receiver stalls, every stage holds its word,
//   so nothing is lost or repeated, and s_ready drops.
// Reset
//   aresetn (synchronous, active low) empties the pipe and restores the
//   registers: origin 0, centre (0,0,-1.0), radius 0.5.
`include "ray_sphere_shade_assert.svh"
module ray_sphere_shade #(
    parameter int FRAC_BITS   = rss_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = rss_pkg::COORD_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [rss_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_WIDTH-1:0]         cfg_data,
    // ray directions in
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [COORD_WIDTH-1:0]  s_dir_x,
    input  logic signed [COORD_WIDTH-1:0]  s_dir_y,
    input  logic signed [COORD_WIDTH-1:0]  s_dir_z,
    // colours out
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_red,
    output logic [7:0]                     m_green,
    output logic [7:0]                     m_blue,
    output logic                           m_hit,
    output logic                           m_degenerate
);
    localparam int CW   = COORD_WIDTH;
    localparam int NB   = rss_pkg::NORM_BITS;
    localparam int OCW  = CW + 1;            // origin - centre
    localparam int AW   = 2 * CW;            // |d|^2
    localparam int PRW  = 2 * CW + 1;        // oc_i * d_i
    localparam int OOW  = 2 * CW + 2;        // |oc|^2
    localparam int RRW  = 2 * CW - 2;        // r^2
    localparam int HBW  = 2 * CW + 2;        // half_b, signed
    localparam int CWD  = 2 * CW + 3;        // c, signed
    localparam int HMW  = 2 * CW + 1;        // -half_b
    localparam int CUW  = 2 * CW + 2;        // c when positive
    localparam int DSW  = 4 * CW + 2;        // discriminant
    localparam int SW   = (DSW + 1) / 2;     // its root
    localparam int PXW  = 3 * CW + 2;        // normal partial terms
    localparam int WW   = 3 * CW + 3;        // normal, signed
    localparam int MW   = WW - 1;            // normal magnitude
    localparam int SHW  = $clog2(MW + 1);
    localparam int SQW  = 2 * NB + 2;        // |m|^2
    localparam int LW   = (SQW + 1) / 2;     // normal length
    localparam int NUMW = (LW + 1 > CW + 5) ? LW + 1 : CW + 5;
    localparam int DENW = 15 + ((LW > CW) ? LW : CW);
    localparam int XW   = (NUMW + 18 > DENW + 8) ? NUMW + 18 : DENW + 8;

    localparam logic [CW-1:0]   CZ_RST  = CW'(-(longint'(1) << FRAC_BITS));
    localparam logic [CW-2:0]   RAD_RST = (CW-1)'(longint'(1) << (FRAC_BITS - 1));

    typedef struct packed {
        logic           hit;
        logic           deg;
        logic [HMW-1:0] hbm;
        logic [AW-1:0]  a;
    } pla_t;

    typedef struct packed {
        logic [2:0][CW-1:0]  d;
        logic [2:0][OCW-1:0] oc;
    } plb_t;

    typedef struct packed {
        logic               hit;
        logic               deg;
        logic [2:0][NB-1:0] m;
        logic [2:0]         neg;
        logic [CW-1:0]      len_s;
        logic [CW-1:0]      ym;
        logic               yneg;
    } plc_t;

    logic m_valid_reg;
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---------------- configuration registers ----------------
    logic signed [CW-1:0] origin_reg [3];
    logic signed [CW-1:0] center_reg [3];
    logic [CW-2:0]        radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= CZ_RST;
            radius_reg    <= RAD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rss_pkg::REG_ORIGIN_X: origin_reg[0] <= cfg_data;
                rss_pkg::REG_ORIGIN_Y: origin_reg[1] <= cfg_data;
                rss_pkg::REG_ORIGIN_Z: origin_reg[2] <= cfg_data;
                rss_pkg::REG_CENTER_X: center_reg[0] <= cfg_data;
                rss_pkg::REG_CENTER_Y: center_reg[1] <= cfg_data;
                rss_pkg::REG_CENTER_Z: center_reg[2] <= cfg_data;
                rss_pkg::REG_RADIUS:   radius_reg    <= cfg_data[CW-2:0];
                default: ;
            endcase
        end
    end

    // ---------------- valid chain ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v6_reg, v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;
    logic v12_reg, v13_reg, v14_reg;
    logic sqa_vld, sqb_vld, sqc_vld;
    logic dv_reg [8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
            v9_reg <= 1'b0; v10_reg <= 1'b0; v11_reg <= 1'b0; v12_reg <= 1'b0;
            v13_reg <= 1'b0; v14_reg <= 1'b0; m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= sqa_vld;
            v7_reg      <= v6_reg;
            v8_reg      <= v7_reg;
            v9_reg      <= v8_reg;
            v10_reg     <= v9_reg;
            v11_reg     <= v10_reg;
            v12_reg     <= sqc_vld;
            v13_reg     <= v12_reg;
            v14_reg     <= v13_reg;
            m_valid_reg <= dv_reg[7];
        end
    end

    // ---------------- stage 1: capture direction, oc = O - C ----------------
    logic signed [CW-1:0]  d1_reg  [3];
    logic signed [OCW-1:0] oc1_reg [3];
    logic                  deg1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg[0] <= s_dir_x;
            d1_reg[1] <= s_dir_y;
            d1_reg[2] <= s_dir_z;
            for (int i = 0; i < 3; i++) begin
                oc1_reg[i] <= $signed({origin_reg[i][CW-1], origin_reg[i]})
                            - $signed({center_reg[i][CW-1], center_reg[i]});
            end
            deg1_reg <= (s_dir_x == '0) && (s_dir_y == '0) && (s_dir_z == '0);
        end
    end

    // ---------------- stage 2: products ----------------
    logic [AW-1:0]         dd2_reg [3];
    logic signed [PRW-1:0] od2_reg [3];
    logic [2*CW:0]         oo2_reg [3];
    logic [RRW-1:0]        rr2_reg;
    logic signed [CW-1:0]  d2_reg  [3];
    logic signed [OCW-1:0] oc2_reg [3];
    logic                  deg2_reg;

    logic signed [2*CW-1:0] dd_p [3];
    logic signed [PRW-1:0]  od_p [3];
    logic signed [2*CW+1:0] oo_p [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dd_p[i] = d1_reg[i] * d1_reg[i];
            od_p[i] = oc1_reg[i] * d1_reg[i];
            oo_p[i] = oc1_reg[i] * oc1_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dd2_reg[i] <= $unsigned(dd_p[i]);
                od2_reg[i] <= od_p[i];
                oo2_reg[i] <= oo_p[i][2*CW:0];
                d2_reg[i]  <= d1_reg[i];
                oc2_reg[i] <= oc1_reg[i];
            end
            rr2_reg  <= RRW'(radius_reg) * RRW'(radius_reg);
            deg2_reg <= deg1_reg;
        end
    end

    // ---------------- stage 3: a, half_b, c ----------------
    logic [AW-1:0]         a3_reg;
    logic signed [HBW-1:0] hb3_reg;
    logic signed [CWD-1:0] c3_reg;
    logic signed [CW-1:0]  d3_reg  [3];
    logic signed [OCW-1:0] oc3_reg [3];
    logic                  deg3_reg;
    logic [OOW-1:0]        oos;

    assign oos = OOW'(oo2_reg[0]) + OOW'(oo2_reg[1]) + OOW'(oo2_reg[2]);

    always_ff @(posedge aclk) begin
        if (en) begin
            a3_reg  <= dd2_reg[0] + dd2_reg[1] + dd2_reg[2];
            hb3_reg <= HBW'(od2_reg[0]) + HBW'(od2_reg[1]) + HBW'(od2_reg[2]);
            c3_reg  <= $signed({1'b0, oos}) - $signed({{(CWD-RRW){1'b0}}, rr2_reg});
            for (int i = 0; i < 3; i++) begin
                d3_reg[i]  <= d2_reg[i];
                oc3_reg[i] <= oc2_reg[i];
            end
            deg3_reg <= deg2_reg;
        end
    end

    // ---------------- stage 4: half_b^2 and a*c ----------------
    logic [DSW-1:0]        hb2_4_reg, ac4_reg;
    logic [HMW-1:0]        hbm4_reg;
    logic [AW-1:0]         a4_reg;
    logic                  cand4_reg, deg4_reg;
    logic signed [CW-1:0]  d4_reg  [3];
    logic signed [OCW-1:0] oc4_reg [3];
    logic [HMW-1:0]        hbm_n;
    logic [CUW-1:0]        cu_n;

    assign hbm_n = HMW'(-hb3_reg);
    assign cu_n  = CUW'(c3_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            hb2_4_reg <= DSW'(hbm_n) * DSW'(hbm_n);
            ac4_reg   <= DSW'(a3_reg) * DSW'(cu_n);
            hbm4_reg  <= hbm_n;
            a4_reg    <= a3_reg;
            // hit needs half_b < 0 and c > 0
            cand4_reg <= hb3_reg[HBW-1] && !c3_reg[CWD-1] && (c3_reg != '0) && !deg3_reg;
            deg4_reg  <= deg3_reg;
            for (int i = 0; i < 3; i++) begin
                d4_reg[i]  <= d3_reg[i];
                oc4_reg[i] <= oc3_reg[i];
            end
        end
    end

    // ---------------- stage 5: discriminant ----------------
    logic [DSW-1:0] disc5_reg;
    pla_t           pla5_reg;
    plb_t           plb5_reg;
    logic           ge4;

    assign ge4 = hb2_4_reg >= ac4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            disc5_reg <= (cand4_reg && ge4) ? (hb2_4_reg - ac4_reg) : '0;
            pla5_reg  <= '{hit: cand4_reg && ge4, deg: deg4_reg, hbm: hbm4_reg, a: a4_reg};
            for (int i = 0; i < 3; i++) begin
                plb5_reg.d[i]  <= d4_reg[i];
                plb5_reg.oc[i] <= oc4_reg[i];
            end
        end
    end

    // ---------------- root of disc, and in step the root of a ----------------
    logic [SW-1:0]           sqa_root, sqb_root;
    logic [$bits(pla_t)-1:0] pla_bits;
    logic [$bits(plb_t)-1:0] plb_bits;
    pla_t                    pla6;
    plb_t                    plb6;

    rss_isqrt #(.IW(DSW), .PW($bits(pla_t))) u_sqrt_disc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_value  (disc5_reg),
        .in_pl     (pla5_reg),
        .out_valid (sqa_vld),
        .out_root  (sqa_root),
        .out_pl    (pla_bits)
    );

    rss_isqrt #(.IW(DSW), .PW($bits(plb_t))) u_sqrt_dir (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_value  ({{(DSW-AW){1'b0}}, pla5_reg.a}),
        .in_pl     (plb5_reg),
        .out_valid (sqb_vld),
        .out_root  (sqb_root),
        .out_pl    (plb_bits)
    );

    assign pla6 = pla_t'(pla_bits);
    assign plb6 = plb_t'(plb_bits);

    // ---------------- stage 6: normal terms, sky set-up ----------------
    logic signed [PXW-1:0] oca6_reg [3];
    logic signed [PXW-1:0] kd6_reg  [3];
    logic                  hit6_reg, deg6_reg;
    logic [CW-1:0]         len6_reg, ym6_reg;
    logic                  yneg6_reg;
    logic [HMW-1:0]        k_n;
    logic [CW-1:0]         lsky_n, yabs_n;

    assign k_n    = pla6.hbm - HMW'(sqa_root);
    assign lsky_n = (sqb_root[CW-1:0] == '0) ? CW'(1) : sqb_root[CW-1:0];
    assign yabs_n = plb6.d[1][CW-1] ? (~plb6.d[1] + CW'(1)) : plb6.d[1];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                oca6_reg[i] <= $signed(plb6.oc[i]) * $signed({1'b0, pla6.a});
                kd6_reg[i]  <= $signed({1'b0, k_n}) * $signed(plb6.d[i]);
            end
            hit6_reg  <= pla6.hit;
            deg6_reg  <= pla6.deg;
            len6_reg  <= lsky_n;
            ym6_reg   <= (yabs_n > lsky_n) ? lsky_n : yabs_n;
            yneg6_reg <= plb6.d[1][CW-1];
        end
    end

    // ---------------- stage 7: normal w = oc*a + k*d ----------------
    logic [MW-1:0]   m7_reg [3];
    logic [2:0]      neg7_reg;
    logic            hit7_reg, deg7_reg, yneg7_reg;
    logic [CW-1:0]   len7_reg, ym7_reg;
    logic signed [WW-1:0] w_n [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_n[i] = WW'(oca6_reg[i]) + WW'(kd6_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                neg7_reg[i] <= w_n[i][WW-1];
                m7_reg[i]   <= w_n[i][WW-1] ? MW'(-w_n[i]) : MW'(w_n[i]);
            end
            hit7_reg  <= hit6_reg;
            deg7_reg  <= deg6_reg;
            len7_reg  <= len6_reg;
            ym7_reg   <= ym6_reg;
            yneg7_reg <= yneg6_reg;
        end
    end

    // ---------------- stage 8: shift needed to fit NB bits ----------------
    logic [MW-1:0]  m8_reg [3];
    logic [2:0]     neg8_reg;
    logic [SHW-1:0] sh8_reg;
    logic           hit8_reg, deg8_reg, yneg8_reg;
    logic [CW-1:0]  len8_reg, ym8_reg;
    logic [MW-1:0]  orv;
    logic [SHW-1:0] msb_n, sh_n;

    // msb of the largest magnitude is the msb of their OR
    always_comb begin
        orv   = m7_reg[0] | m7_reg[1] | m7_reg[2];
        msb_n = '0;
        for (int b = 0; b < MW; b++) begin
            if (orv[b]) msb_n = SHW'(b);
        end
        sh_n = (msb_n >= SHW'(NB)) ? (msb_n + SHW'(1) - SHW'(NB)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) m8_reg[i] <= m7_reg[i];
            neg8_reg  <= neg7_reg;
            sh8_reg   <= sh_n;
            hit8_reg  <= hit7_reg;
            deg8_reg  <= deg7_reg;
            len8_reg  <= len7_reg;
            ym8_reg   <= ym7_reg;
            yneg8_reg <= yneg7_reg;
        end
    end

    // ---------------- stage 9: apply shift ----------------
    logic [NB-1:0] m9_reg [3];
    logic [2:0]    neg9_reg;
    logic          hit9_reg, deg9_reg, yneg9_reg;
    logic [CW-1:0] len9_reg, ym9_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) m9_reg[i] <= NB'(m8_reg[i] >> sh8_reg);
            neg9_reg  <= neg8_reg;
            hit9_reg  <= hit8_reg;
            deg9_reg  <= deg8_reg;
            len9_reg  <= len8_reg;
            ym9_reg   <= ym8_reg;
            yneg9_reg <= yneg8_reg;
        end
    end

    // ---------------- stage 10: squares ----------------
    logic [2*NB-1:0] sqm10_reg [3];
    logic [NB-1:0]   m10_reg   [3];
    logic [2:0]      neg10_reg;
    logic            hit10_reg, deg10_reg, yneg10_reg;
    logic [CW-1:0]   len10_reg, ym10_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sqm10_reg[i] <= (2*NB)'(m9_reg[i]) * (2*NB)'(m9_reg[i]);
                m10_reg[i]   <= m9_reg[i];
            end
            neg10_reg  <= neg9_reg;
            hit10_reg  <= hit9_reg;
            deg10_reg  <= deg9_reg;
            len10_reg  <= len9_reg;
            ym10_reg   <= ym9_reg;
            yneg10_reg <= yneg9_reg;
        end
    end

    // ---------------- stage 11: |m|^2 ----------------
    logic [SQW-1:0] sq11_reg;
    plc_t           plc11_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq11_reg <= SQW'(sqm10_reg[0]) + SQW'(sqm10_reg[1]) + SQW'(sqm10_reg[2]);
            for (int i = 0; i < 3; i++) plc11_reg.m[i] <= m10_reg[i];
            plc11_reg.neg   <= neg10_reg;
            plc11_reg.hit   <= hit10_reg;
            plc11_reg.deg   <= deg10_reg;
            plc11_reg.len_s <= len10_reg;
            plc11_reg.ym    <= ym10_reg;
            plc11_reg.yneg  <= yneg10_reg;
        end
    end

    // ---------------- normal length ----------------
    logic [LW-1:0]           len_root;
    logic [$bits(plc_t)-1:0] plc_bits;
    plc_t                    plc12;

    rss_isqrt #(.IW(SQW), .PW($bits(plc_t))) u_sqrt_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v11_reg),
        .in_value  (sq11_reg),
        .in_pl     (plc11_reg),
        .out_valid (sqc_vld),
        .out_root  (len_root),
        .out_pl    (plc_bits)
    );

    assign plc12 = plc_t'(plc_bits);

    // ---------------- stage 12: numerators, denominators ----------------
    logic [NUMW-1:0] num12_reg [3];
    logic [DENW-1:0] den12_reg [3];
    rss_pkg::ovr_t   ovr12_reg [3];
    logic            hit12_reg, deg12_reg;

    logic [NUMW-1:0] num_n [3];
    logic [DENW-1:0] den_n [3];
    rss_pkg::ovr_t   ovr_n [3];
    logic [NUMW-1:0] lsn, ymn;

    always_comb begin
        lsn = NUMW'(plc12.len_s);
        ymn = NUMW'(plc12.ym);
        for (int i = 0; i < 3; i++) begin
            num_n[i] = '0;
            den_n[i] = '0;
            ovr_n[i] = rss_pkg::OVR_NONE;
            if (plc12.deg) begin
                ovr_n[i] = rss_pkg::OVR_ZERO;
            end else if (plc12.hit) begin
                if (len_root == '0) begin
                    ovr_n[i] = rss_pkg::OVR_MID;
                end
                num_n[i] = plc12.neg[i] ? (NUMW'(len_root) - NUMW'(plc12.m[i]))
                                        : (NUMW'(len_root) + NUMW'(plc12.m[i]));
                den_n[i] = DENW'(len_root) * DENW'(rss_pkg::HIT_DEN);
            end
        end
        // sky blend
        if (!plc12.deg && !plc12.hit) begin
            num_n[0] = plc12.yneg ? (lsn * NUMW'(rss_pkg::SKY_R_L) + ymn)
                                  : (lsn * NUMW'(rss_pkg::SKY_R_L) - ymn);
            den_n[0] = DENW'(plc12.len_s) * DENW'(rss_pkg::SKY_R_DEN);
            num_n[1] = plc12.yneg
                ? (lsn * NUMW'(rss_pkg::SKY_G_L) + ymn * NUMW'(rss_pkg::SKY_G_Y))
                : (lsn * NUMW'(rss_pkg::SKY_G_L) - ymn * NUMW'(rss_pkg::SKY_G_Y));
            den_n[1] = DENW'(plc12.len_s) * DENW'(rss_pkg::SKY_G_DEN);
            ovr_n[2] = rss_pkg::OVR_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num12_reg[i] <= num_n[i];
                den12_reg[i] <= den_n[i];
                ovr12_reg[i] <= ovr_n[i];
            end
            hit12_reg <= plc12.hit && !plc12.deg;
            deg12_reg <= plc12.deg;
        end
    end

    // ---------------- stage 13: scaled numerator ----------------
    logic [XW-1:0]   p13_reg   [3];
    logic [DENW-1:0] den13_reg [3];
    rss_pkg::ovr_t   ovr13_reg [3];
    logic            hit13_reg, deg13_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p13_reg[i]   <= XW'(num12_reg[i]) * XW'(rss_pkg::SCALE_NUM);
                den13_reg[i] <= den12_reg[i];
                ovr13_reg[i] <= ovr12_reg[i];
            end
            hit13_reg <= hit12_reg;
            deg13_reg <= deg12_reg;
        end
    end

    // ---------------- stage 14: saturation check ----------------
    logic [XW-1:0]   rem14_reg [3];
    logic [DENW-1:0] den14_reg [3];
    rss_pkg::ovr_t   ovr14_reg [3];
    logic            hit14_reg, deg14_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                rem14_reg[i] <= p13_reg[i];
                den14_reg[i] <= den13_reg[i];
                // quotient of 256 or more saturates
                if (ovr13_reg[i] == rss_pkg::OVR_NONE
                        && p13_reg[i] >= (XW'(den13_reg[i]) << 8)) begin
                    ovr14_reg[i] <= rss_pkg::OVR_FULL;
                end else begin
                    ovr14_reg[i] <= ovr13_reg[i];
                end
            end
            hit14_reg <= hit13_reg;
            deg14_reg <= deg13_reg;
        end
    end

    // ---------------- 8-step restoring divider, one quotient bit a stage ----------------
    logic [XW-1:0]   drem_reg [8][3];
    logic [7:0]      dq_reg   [8][3];
    logic [DENW-1:0] dden_reg [8][3];
    rss_pkg::ovr_t   dovr_reg [8][3];
    logic            dhit_reg [8];
    logic            ddeg_reg [8];

    for (genvar j = 0; j < 8; j++) begin : g_div
        localparam int B = 7 - j;
        logic [XW-1:0]   rem_src [3];
        logic [7:0]      q_src   [3];
        logic [DENW-1:0] den_src [3];
        rss_pkg::ovr_t   ovr_src [3];
        logic            hit_src, deg_src, v_src;
        logic [XW-1:0]   dsh     [3];

        if (j == 0) begin : g_first
            assign rem_src = rem14_reg;
            assign den_src = den14_reg;
            assign ovr_src = ovr14_reg;
            assign q_src   = '{8'd0, 8'd0, 8'd0};
            assign hit_src = hit14_reg;
            assign deg_src = deg14_reg;
            assign v_src   = v14_reg;
        end else begin : g_chain
            assign rem_src = drem_reg[j-1];
            assign den_src = dden_reg[j-1];
            assign ovr_src = dovr_reg[j-1];
            assign q_src   = dq_reg[j-1];
            assign hit_src = dhit_reg[j-1];
            assign deg_src = ddeg_reg[j-1];
            assign v_src   = dv_reg[j-1];
        end

        always_comb begin
            for (int i = 0; i < 3; i++) dsh[i] = XW'(den_src[i]) << B;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j] <= 1'b0;
            end else if (en) begin
                dv_reg[j] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (rem_src[i] >= dsh[i]) begin
                        drem_reg[j][i] <= rem_src[i] - dsh[i];
                        dq_reg[j][i]   <= q_src[i] | (8'd1 << B);
                    end else begin
                        drem_reg[j][i] <= rem_src[i];
                        dq_reg[j][i]   <= q_src[i];
                    end
                    dden_reg[j][i] <= den_src[i];
                    dovr_reg[j][i] <= ovr_src[i];
                end
                dhit_reg[j] <= hit_src;
                ddeg_reg[j] <= deg_src;
            end
        end
    end

    // ---------------- output register ----------------
    logic [7:0] byte_n [3];
    logic [7:0] red_reg, green_reg, blue_reg;
    logic       hit_reg, deg_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (dovr_reg[7][i])
                rss_pkg::OVR_ZERO: byte_n[i] = rss_pkg::BYTE_ZERO;
                rss_pkg::OVR_MID:  byte_n[i] = rss_pkg::BYTE_MID;
                rss_pkg::OVR_FULL: byte_n[i] = rss_pkg::BYTE_FULL;
                default:           byte_n[i] = dq_reg[7][i];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg   <= byte_n[0];
            green_reg <= byte_n[1];
            blue_reg  <= byte_n[2];
            hit_reg   <= dhit_reg[7];
            deg_reg   <= ddeg_reg[7];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red        = red_reg;
    assign m_green      = green_reg;
    assign m_blue       = blue_reg;
    assign m_hit        = hit_reg;
    assign m_degenerate = deg_reg;

    // ---------------- checks ----------------
    // the two root pipes run in lock step
    `RSS_ASSERT_NOW(a_roots_aligned, 1'b1, sqa_vld == sqb_vld)
    // zero direction: black, never a hit
    `RSS_ASSERT_NOW(a_deg_black, m_valid && m_degenerate, !m_hit && ({m_red, m_green, m_blue} == 24'd0))
    // sky is always full blue
    `RSS_ASSERT_NOW(a_sky_blue, m_valid && !m_hit && !m_degenerate, m_blue == 8'd255)
    // a stalled stage 14 keeps its valid
    `RSS_ASSERT_NEXT(a_stall_holds, v14_reg && !en, v14_reg)

endmodule

[dv/tb_ray_sphere_shade.sv]
// tb_ray_sphere_shade: self-checking testbench for the ray/sphere shader.
// Depends on rss_pkg and ray_sphere_shade; the expected colours come from an
// integer shading model kept in the shade_board class below.
`timescale 1ns / 100ps

module tb_ray_sphere_shade;

    localparam int CW = rss_pkg::COORD_WIDTH_DEF;
    localparam int NUM_REGS = 7;
    localparam logic [rss_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;   // no register here
    localparam int PIPE_DEPTH = 2 * CW + 55;              // register stages from s_* to m_*
    localparam int CYCLE_LIMIT = 300000;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       hit;
        logic       degenerate;
    } colour_t;

    // receiver stall patterns
    typedef enum int { RX_ALWAYS, RX_COIN, RX_PERIODIC } rx_mode_t;

    // ------------------------------------------------------------------
    // Shading model plus the queue of colours still owed by the block
    // ------------------------------------------------------------------
    class shade_board;
        logic [CW-1:0] regs[NUM_REGS];
        colour_t       owed[$];
        int            errors, n_hit, n_sky, n_degen, n_checked;

        function new();
            reset_regs();
        endfunction

        function void reset_regs();
            foreach (regs[i]) regs[i] = '0;
            regs[rss_pkg::REG_CENTER_Z] = CW'(-(1 << rss_pkg::FRAC_BITS_DEF));
            regs[rss_pkg::REG_RADIUS]   = CW'(1 << (rss_pkg::FRAC_BITS_DEF - 1));
        endfunction

        function void set_reg(logic [rss_pkg::REG_IDX_W-1:0] idx, logic [CW-1:0] val);
            if (idx == REG_UNUSED) return;
            regs[idx] = (idx == rss_pkg::REG_RADIUS) ? {1'b0, val[CW-2:0]} : val;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // floor square root of a 128-bit value, bit by bit
        function logic [63:0] root_floor(logic [127:0] v);
            logic [63:0] r, t;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (128'(t) * 128'(t) <= v) r = t;
            end
            return r;
        endfunction

        function logic [7:0] to_byte(longint unsigned num, longint unsigned den);
            longint unsigned q;
            q = (64'd255999 * num) / den;
            return (q > 255) ? rss_pkg::BYTE_FULL : q[7:0];
        endfunction

        // work out the colour of an accepted ray and queue it
        function void note_ray(coord_t dx, coord_t dy, coord_t dz);
            longint d[3], oc[3], w[3];
            longint unsigned m[3], mx, sq, len, my, s;
            longint a, hb, oc2, c, rad, k;
            logic [127:0] hb2, ac;
            int sh;
            colour_t col;
            d[0] = dx; d[1] = dy; d[2] = dz;
            a = 0; hb = 0; oc2 = 0;
            for (int i = 0; i < 3; i++) begin
                oc[i] = longint'($signed(regs[i])) - longint'($signed(regs[3 + i]));
                a   += d[i] * d[i];
                hb  += oc[i] * d[i];
                oc2 += oc[i] * oc[i];
            end
            rad = longint'(regs[rss_pkg::REG_RADIUS][CW-2:0]);
            c = oc2 - rad * rad;
            col = '0;
            if (a == 0) begin
                col.degenerate = 1'b1;
                owed.push_back(col);
                return;
            end
            if (hb < 0 && c > 0) begin
                hb2 = 128'(-hb) * 128'(-hb);
                ac  = 128'(a) * 128'(c);
                if (hb2 >= ac) begin
                    s = root_floor(hb2 - ac);
                    k = -hb - longint'(s);
                    mx = 0;
                    for (int i = 0; i < 3; i++) begin
                        w[i] = oc[i] * a + k * d[i];
                        m[i] = (w[i] < 0) ? -w[i] : w[i];
                        if (m[i] > mx) mx = m[i];
                    end
                    sh = 0;
                    while ((mx >> sh) >= (64'd1 << rss_pkg::NORM_BITS)) sh++;
                    sq = 0;
                    for (int i = 0; i < 3; i++) begin
                        m[i] = m[i] >> sh;
                        sq += m[i] * m[i];
                    end
                    len = root_floor(128'(sq));
                    col.hit = 1'b1;
                    if (len == 0) begin
                        col.red   = rss_pkg::BYTE_MID;
                        col.green = rss_pkg::BYTE_MID;
                        col.blue  = rss_pkg::BYTE_MID;
                    end else begin
                        col.red   = to_byte(w[0] < 0 ? len - m[0] : len + m[0],
                                            rss_pkg::HIT_DEN * len);
                        col.green = to_byte(w[1] < 0 ? len - m[1] : len + m[1],
                                            rss_pkg::HIT_DEN * len);
                        col.blue  = to_byte(w[2] < 0 ? len - m[2] : len + m[2],
                                            rss_pkg::HIT_DEN * len);
                    end
                    owed.push_back(col);
                    return;
                end
            end
            // sky blend on the direction's y
            len = root_floor(128'(a));
            if (len == 0) len = 1;
            my = (d[1] < 0) ? -d[1] : d[1];
            if (my > len) my = len;
            col.red   = to_byte(d[1] < 0 ? rss_pkg::SKY_R_L * len + my
                                         : rss_pkg::SKY_R_L * len - my,
                                rss_pkg::SKY_R_DEN * len);
            col.green = to_byte(d[1] < 0 ? rss_pkg::SKY_G_L * len + rss_pkg::SKY_G_Y * my
                                         : rss_pkg::SKY_G_L * len - rss_pkg::SKY_G_Y * my,
                                rss_pkg::SKY_G_DEN * len);
            col.blue  = rss_pkg::BYTE_FULL;
            owed.push_back(col);
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("[%0t] colour word %0d: %s got %0d expected %0d",
                     $time, n_checked, what, got, want);
        endtask

        task check_colour(colour_t got);
            colour_t want;
            if (owed.size() == 0) begin
                report("unexpected word, red", got.red, 0);
                return;
            end
            want = owed.pop_front();
            if (got.red != want.red)               report("red", got.red, want.red);
            if (got.green != want.green)           report("green", got.green, want.green);
            if (got.blue != want.blue)             report("blue", got.blue, want.blue);
            if (got.hit != want.hit)               report("hit", got.hit, want.hit);
            if (got.degenerate != want.degenerate)
                report("degenerate", got.degenerate, want.degenerate);
            n_checked++;
            if (want.degenerate) n_degen++;
            else if (want.hit)   n_hit++;
            else                 n_sky++;
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------
    logic                          aclk, aresetn;
    logic                          cfg_wr_en;
    logic [rss_pkg::REG_IDX_W-1:0] cfg_index;
    logic [CW-1:0]                 cfg_data;
    logic                          s_valid, s_ready;
    coord_t                        s_dir_x, s_dir_y, s_dir_z;
    logic                          m_valid, m_ready;
    logic [7:0]                    m_red, m_green, m_blue;
    logic                          m_hit, m_degenerate;

    ray_sphere_shade dut (.*);

    shade_board board = new();
    rx_mode_t   rx_mode = RX_ALWAYS;
    bit         long_hold = 0;    // raised by the stimulus, cleared by the receiver
    bit         tx_gaps = 1;      // sender idles between bursts
    int         cycles = 0;

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still owed", cycles, board.pending());
            $display("ray_sphere_shade: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: take a word on each handshake, then choose next m_ready
    // ------------------------------------------------------------------
    initial begin
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                board.check_colour({m_red, m_green, m_blue, m_hit, m_degenerate});
            if (long_hold) begin
                // long back-pressure: the pipe fills and s_ready must drop
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                long_hold = 0;
                m_ready <= 1;
            end else if (aresetn) begin
                case (rx_mode)
                    RX_ALWAYS:   m_ready <= 1;
                    RX_COIN:     m_ready <= 1'($urandom_range(1));
                    RX_PERIODIC: m_ready <= (cycles % 7) >= 3;
                    default:     m_ready <= 1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers; every task starts and ends just after a rising edge
    // ------------------------------------------------------------------
    task send_ray(coord_t dx, coord_t dy, coord_t dz);
        s_valid <= 1;
        s_dir_x <= dx;
        s_dir_y <= dy;
        s_dir_z <= dz;
        do @(posedge aclk); while (!(s_valid && s_ready));
        board.note_ray(dx, dy, dz);
    endtask

    task go_idle(int n);
        s_valid <= 0;
        repeat (n) @(posedge aclk);
    endtask

    // write only when the pipe is empty and has settled
    task drain();
        go_idle(1);
        while (board.pending() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 8) @(posedge aclk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task write_reg(logic [rss_pkg::REG_IDX_W-1:0] idx, logic [CW-1:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        board.set_reg(idx, val);
    endtask

    task set_scene(coord_t ox, coord_t oy, coord_t oz, coord_t cx, coord_t cy, coord_t cz,
                   logic [CW-1:0] r);
        drain();
        write_reg(rss_pkg::REG_ORIGIN_X, ox);
        write_reg(rss_pkg::REG_ORIGIN_Y, oy);
        write_reg(rss_pkg::REG_ORIGIN_Z, oz);
        write_reg(rss_pkg::REG_CENTER_X, cx);
        write_reg(rss_pkg::REG_CENTER_Y, cy);
        write_reg(rss_pkg::REG_CENTER_Z, cz);
        write_reg(rss_pkg::REG_RADIUS, r);
        cfg_wr_en <= 0;
    endtask

    function coord_t clip(longint v);
        if (v > 32767)  return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return coord_t'(v);
    endfunction

    function coord_t pick_coord();
        case ($urandom_range(3))
            0:       return coord_t'($urandom);
            1:       return coord_t'($urandom_range(8191)) - 4096;
            2: begin
                case ($urandom_range(4))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: return coord_t'($urandom_range(65535));
        endcase
    endfunction

    // random rays in bursts; most are aimed near the sphere centre
    task run_rays(int n);
        int left, burst;
        longint aim[3];
        left = n;
        while (left > 0) begin
            burst = $urandom_range(16, 1);
            if (burst > left) burst = left;
            for (int j = 0; j < burst; j++) begin
                if ($urandom_range(99) < 60) begin
                    for (int i = 0; i < 3; i++)
                        aim[i] = longint'($signed(board.regs[3 + i]))
                               - longint'($signed(board.regs[i]))
                               + longint'($urandom_range(4095)) - 2048;
                    send_ray(clip(aim[0]), clip(aim[1]), clip(aim[2]));
                end else begin
                    send_ray(pick_coord(), pick_coord(), pick_coord());
                end
            end
            left -= burst;
            if (tx_gaps) go_idle($urandom_range(5, 1));
        end
    endtask

    function coord_t scene_coord(bit wide);
        return wide ? coord_t'($urandom) : coord_t'($urandom_range(16383)) - 8192;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        bit wide;
        aresetn   = 0;
        cfg_wr_en = 0;
        cfg_index = rss_pkg::REG_ORIGIN_X;
        cfg_data  = '0;
        s_valid   = 0;
        s_dir_x   = 0;
        s_dir_y   = 0;
        s_dir_z   = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // reset scene: unit-ish sphere straight ahead
        send_ray(0, 0, 0);                        // zero direction
        send_ray(0, 0, -4096);                    // dead centre hit
        send_ray(1024, 1024, -4096);              // off-centre hit
        send_ray(0, 4096, 0);                     // sky, looking up
        send_ray(0, -4096, 0);                    // sky, looking down
        send_ray(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_ray(16'sh8000, 16'sh8000, 16'sh8000);
        send_ray(0, 0, 16'sh8000);
        send_ray(1, 0, 0);
        send_ray(0, 16'sh8000, 0);

        // grazing ray: line passes exactly one radius from the centre
        set_scene(0, 0, 0, 4096, 0, -8192, 4096);
        send_ray(0, 0, -4096);
        send_ray(0, 0, 4096);                     // tangent point behind the origin

        // zero radius with the origin on the ray: normal has no length
        set_scene(0, 0, 0, 0, 0, -4096, 0);
        send_ray(0, 0, -1);
        send_ray(0, 0, -4096);

        // origin inside the sphere gives sky; stray index must be ignored
        set_scene(0, 0, 0, 0, 0, 0, 2048);
        write_reg(REG_UNUSED, 16'h1234);
        cfg_wr_en <= 0;
        send_ray(0, 0, -4096);
        send_ray(0, 4096, 4096);

        // origin exactly on the surface
        set_scene(0, 0, 0, 0, 0, -4096, 4096);
        send_ray(0, 0, -4096);

        // register extremes, radius value wider than its field
        set_scene(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff);
        send_ray(16'sh8000, 16'sh8000, 16'sh8000);
        send_ray(16'sh7fff, 0, 0);
        set_scene(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        send_ray(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_ray(0, 0, 0);

        // random scenes under varying flow-control patterns
        for (int ph = 0; ph < 8; ph++) begin
            wide = (ph % 3) == 2;
            set_scene(scene_coord(wide), scene_coord(wide), scene_coord(wide),
                      scene_coord(wide), scene_coord(wide), scene_coord(wide),
                      wide ? CW'($urandom) : CW'($urandom_range(8192)));
            rx_mode = rx_mode_t'(ph % 3);
            tx_gaps = (ph % 4) != 1;
            if (ph == 4) long_hold = 1;            // sender keeps pushing meanwhile
            run_rays(120);
        end

        // back to the reset scene values by hand
        set_scene(0, 0, 0, 0, 0, -4096, 2048);
        rx_mode = RX_COIN;
        run_rays(40);

        go_idle(1);
        while (board.pending() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 20) @(posedge aclk);

        $display("checked %0d colour words: %0d sphere hits, %0d sky, %0d zero directions",
                 board.n_checked, board.n_hit, board.n_sky, board.n_degen);
        $display("scenes covered reset, grazing, zero radius, inside, extremes and 8 random");
        if (board.errors == 0) begin
            $display("ray_sphere_shade: match");
        end else begin
            $display("%0d field errors", board.errors);
            $display("ray_sphere_shade: mismatch");
        end
        $finish;
    end

endmodule
